### rtl/core/lrbc_pkg.sv
// Shared types, field widths and codes of the LRU block read cache.
package lrbc_pkg;

    localparam int ADDR_W  = 32;            // segment ids, offsets, lengths
    localparam int BLK_W   = 21;            // block size register
    localparam int CSTART_W = 20;           // position inside one block
    localparam int MAXU_W  = 5;             // entries-in-use register
    localparam int CNT64_W = 64;            // ticks and running totals
    localparam int SLOT_OUT_W = 4;          // slot field of a result
    localparam int CFG_ADDR_W = 4;

    // Block size limits
    localparam logic [BLK_W-1:0] BLOCK_MIN   = 21'd1;
    localparam logic [BLK_W-1:0] BLOCK_MAX   = 21'd1048576;
    localparam logic [BLK_W-1:0] BLOCK_RESET = 21'd65536;
    localparam logic [MAXU_W-1:0] MAXU_MIN   = 5'd2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_BYTES = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_ENTRIES = 4'd1;

    // Result action codes
    localparam logic [1:0] ACT_BYPASS = 2'd0;
    localparam logic [1:0] ACT_HIT    = 2'd1;
    localparam logic [1:0] ACT_MISS   = 2'd2;

    // Tag part of one cache entry
    typedef struct packed {
        logic [ADDR_W-1:0] seg;
        logic [ADDR_W-1:0] base;
        logic [BLK_W-1:0]  filled;
    } t_tag;

    // Outcome flags of one tag scan
    typedef struct packed {
        logic             hit;
        logic             free_found;
        logic             vic_found;
        logic [BLK_W-1:0] hit_filled;
    } t_scan_flags;

    // One result item
    typedef struct packed {
        logic [1:0]            action;
        logic [SLOT_OUT_W-1:0] slot;
        logic [ADDR_W-1:0]     block_base;
        logic [ADDR_W-1:0]     fill_length;
        logic [CSTART_W-1:0]   copy_start;
        logic [ADDR_W-1:0]     copy_count;
        logic [BLK_W-1:0]      dest_offset;
        logic                  evicted;
        logic [CNT64_W-1:0]    total_bytes_read;
        logic [CNT64_W-1:0]    total_disk_accesses;
        logic                  last;
    } t_result;

endpackage

### rtl/core/lrbc_rem.sv
// Bit-serial restoring remainder unit: offset modulo block size.
module lrbc_rem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lrbc_pkg::ADDR_W-1:0]   i_dividend,
    input  logic [lrbc_pkg::BLK_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [lrbc_pkg::CSTART_W-1:0] o_rem
);
    import lrbc_pkg::*;

    localparam int STEP_W = $clog2(ADDR_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ADDR_W - 1);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [ADDR_W-1:0]   r_quo;
    logic [BLK_W-1:0]    r_rem;
    logic [BLK_W-1:0]    r_div;

    logic [BLK_W:0]      trial;
    logic                fits;
    logic [BLK_W-1:0]    n_rem;

    // Shift in one dividend bit and subtract when the divisor fits
    always_comb begin
        trial = {r_rem, r_quo[ADDR_W-1]};
        fits  = (trial >= {1'b0, r_div});
        n_rem = fits ? BLK_W'(trial - {1'b0, r_div}) : trial[BLK_W-1:0];
    end

    // Control: run one step per cycle, pulse done after the last bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and dividend shifter
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[ADDR_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    // The remainder stays below the divisor, so at most 2^20 - 1
    assign o_rem  = r_rem[CSTART_W-1:0];

endmodule

### rtl/core/lrbc_tags.sv
// Tag and tick store with a one-entry-per-cycle lookup and LRU scan.
module lrbc_tags #(
    parameter  int MAX_ENTRIES = 16,
    localparam int IW = $clog2(MAX_ENTRIES)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // scan request
    input  logic                          i_start,
    input  logic [lrbc_pkg::ADDR_W-1:0]   i_key_seg,
    input  logic [lrbc_pkg::ADDR_W-1:0]   i_key_base,
    input  logic                          i_excl_en,
    input  logic [IW-1:0]                 i_excl,
    // entry update
    input  logic                          i_wr_en,
    input  logic                          i_wr_tag,
    input  logic [IW-1:0]                 i_wr_slot,
    input  lrbc_pkg::t_tag                i_wr_data,
    input  logic [lrbc_pkg::CNT64_W-1:0]  i_wr_tick,
    // scan outcome, held until the next start
    output logic                          o_done,
    output lrbc_pkg::t_scan_flags         o_flags,
    output logic [IW-1:0]                 o_hit_slot,
    output logic [IW-1:0]                 o_free_slot,
    output logic [IW-1:0]                 o_vic_slot,
    output logic [IW:0]                   o_valid_cnt
);
    import lrbc_pkg::*;

    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);

    t_tag                r_tag_mem  [MAX_ENTRIES];
    logic [CNT64_W-1:0]  r_tick_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_valid;

    t_tag                r_rd_tag;
    logic [CNT64_W-1:0]  r_rd_tick;

    logic                r_issue;
    logic [IW-1:0]       r_idx;
    logic                r_chk;
    logic [IW-1:0]       r_cidx;
    logic                r_done;

    t_scan_flags         r_flags;
    logic [IW-1:0]       r_hit_slot;
    logic [IW-1:0]       r_free_slot;
    logic [IW-1:0]       r_vic_slot;
    logic [CNT64_W-1:0]  r_vic_tick;
    logic [IW:0]         r_cnt;

    logic                ent_v;
    logic                match;
    logic                take_vic;

    // Tag memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_tag) begin
            r_tag_mem[i_wr_slot] <= i_wr_data;
        end
        r_rd_tag <= r_tag_mem[r_idx];
    end

    // Tick memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_tick_mem[i_wr_slot] <= i_wr_tick;
        end
        r_rd_tick <= r_tick_mem[r_idx];
    end

    // Valid bits: cleared by reset, set on fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en && i_wr_tag) begin
            r_valid[i_wr_slot] <= 1'b1;
        end
    end

    // Scan sequencer: issue addresses, then check the returned entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_idx   <= '0;
            r_chk   <= 1'b0;
            r_cidx  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_chk  <= r_issue;
            r_cidx <= r_idx;
            r_done <= r_chk && (r_cidx == LAST_IDX);
            if (i_start) begin
                r_issue <= 1'b1;
                r_idx   <= '0;
            end else if (r_issue) begin
                if (r_idx == LAST_IDX) begin
                    r_issue <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    // Compare the entry read last cycle against the key and the running minimum
    always_comb begin
        ent_v    = r_valid[r_cidx];
        match    = ent_v && (r_rd_tag.seg == i_key_seg) && (r_rd_tag.base == i_key_base);
        take_vic = ent_v && !(i_excl_en && (r_cidx == i_excl)) &&
                   (!r_flags.vic_found || (r_rd_tick < r_vic_tick));
    end

    // Accumulate hit, free slot, valid count and LRU victim
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_flags     <= '0;
            r_cnt       <= '0;
            r_hit_slot  <= '0;
            r_free_slot <= '0;
            r_vic_slot  <= '0;
            r_vic_tick  <= '0;
        end else if (r_chk) begin
            r_cnt <= r_cnt + (IW+1)'(ent_v);
            if (match && !r_flags.hit) begin
                r_flags.hit        <= 1'b1;
                r_flags.hit_filled <= r_rd_tag.filled;
                r_hit_slot         <= r_cidx;
            end
            if (!ent_v && !r_flags.free_found) begin
                r_flags.free_found <= 1'b1;
                r_free_slot        <= r_cidx;
            end
            if (take_vic) begin
                r_flags.vic_found <= 1'b1;
                r_vic_slot        <= r_cidx;
                r_vic_tick        <= r_rd_tick;
            end
        end
    end

    assign o_done      = r_done;
    assign o_flags     = r_flags;
    assign o_hit_slot  = r_hit_slot;
    assign o_free_slot = r_free_slot;
    assign o_vic_slot  = r_vic_slot;
    assign o_valid_cnt = r_cnt;

endmodule

### rtl/core/lru_block_read_cache.sv
// Top level of the LRU block read cache: request sequencer, registers, totals.
//
//  channel  | direction | handshake              | contents
//  ---------+-----------+------------------------+----------------------------------------
//  request  | in        | i_s_tvalid/o_s_tready  | i_s_tdata: segment, offset, length, seg len
//  result   | out       | o_m_tvalid/i_m_tready  | o_m_tdata, o_m_tuser (action), o_m_tlast
//  config   | in        | i_cfg_valid/o_cfg_ready| i_cfg_addr, i_cfg_data
//
// A bypass request goes from the accept step straight to the output step. A cached
// request with T = 1 or 2 block touches runs the accept step, the 32-step bit-serial
// remainder unit and one setup step, then per touch a tag scan over all MAX_ENTRIES
// entries plus decide, copy and output steps.
// Reset is synchronous and clears the entry valid bits at once, so no clearing pass
// runs. A stalled result holds in the output register; the sequencer waits in its
// output step while a new result meets a full one.
module lru_block_read_cache #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [31:0] seg_number, [63:32] read_offset, [95:64] read_length, [127:96] seg_length
    input  logic [127:0]                     i_s_tdata,
    // result stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [3:0] slot, [35:4] block_base, [67:36] fill_length, [87:68] copy_start,
    // [119:88] copy_count, [140:120] dest_offset, [141] evicted,
    // [205:142] total_bytes_read, [269:206] total_disk_accesses, [271:270] zero
    output logic [271:0]                     o_m_tdata,
    // [1:0] action
    output logic [1:0]                       o_m_tuser,
    output logic                             o_m_tlast,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lrbc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [lrbc_pkg::BLK_W-1:0]       i_cfg_data
);
    import lrbc_pkg::*;

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int MAXU_RESET_I = (MAX_ENTRIES < 16) ? MAX_ENTRIES : 16;
    localparam logic [MAXU_W-1:0] MAXU_RESET = MAXU_W'(MAXU_RESET_I);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV    = 3'd1;
    localparam logic [2:0] S_PREP   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_COPY   = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [2:0]          r_state;
    logic [2:0]          n_state;

    logic [BLK_W-1:0]    r_block;
    logic [MAXU_W-1:0]   r_max_used;
    logic [CNT64_W-1:0]  r_tick;
    logic [CNT64_W-1:0]  r_bytes;
    logic [CNT64_W-1:0]  r_fetch;

    logic [ADDR_W-1:0]   r_seg;
    logic [ADDR_W-1:0]   r_off;
    logic [ADDR_W-1:0]   r_len;
    logic [ADDR_W-1:0]   r_seglen;

    logic [ADDR_W-1:0]   r_base0;
    logic                r_straddle;
    logic                r_second;
    logic [ADDR_W-1:0]   r_key_base;
    logic [CSTART_W-1:0] r_cstart;
    logic [ADDR_W-1:0]   r_want;
    logic [BLK_W-1:0]    r_dest;
    logic                r_excl_en;
    logic [IW-1:0]       r_excl;
    logic [CNT64_W-1:0]  r_stamp;
    logic                r_start;

    logic [IW-1:0]       r_slot;
    logic                r_miss;
    logic                r_ev;
    logic [ADDR_W-1:0]   r_fill;
    logic [BLK_W-1:0]    r_filled;

    t_result             r_res;
    t_result             r_out;
    logic                r_out_valid;

    // unpacked request fields
    logic [ADDR_W-1:0]   in_seg;
    logic [ADDR_W-1:0]   in_off;
    logic [ADDR_W-1:0]   in_len;
    logic [ADDR_W-1:0]   in_seglen;
    logic                in_xfer;
    logic                in_bypass;

    logic                cfg_xfer;
    logic [BLK_W-1:0]    cfg_block;
    logic [MAXU_W-1:0]   cfg_maxu;

    logic                div_start;
    logic                div_done;
    logic [CSTART_W-1:0] div_rem;

    logic                scan_done;
    t_scan_flags         scan_flags;
    logic [IW-1:0]       hit_slot;
    logic [IW-1:0]       free_slot;
    logic [IW-1:0]       vic_slot;
    logic [IW:0]         valid_cnt;

    logic                room;
    logic [IW-1:0]       pick_slot;
    logic [ADDR_W-1:0]   fill_raw;
    logic [ADDR_W-1:0]   fill_cap;

    logic [BLK_W-1:0]    avail;
    logic [ADDR_W-1:0]   copy_cnt;
    logic [CNT64_W-1:0]  bytes_next;
    logic [CNT64_W-1:0]  fetch_next;
    logic                touch_last;
    logic                out_free;
    logic                wr_en;
    t_tag                wr_data;

    assign in_seg    = i_s_tdata[31:0];
    assign in_off    = i_s_tdata[63:32];
    assign in_len    = i_s_tdata[95:64];
    assign in_seglen = i_s_tdata[127:96];

    assign o_s_tready = (r_state == S_IDLE);
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign in_bypass  = (in_len > ADDR_W'(r_block));

    // Saturate the block size, and the low five bits of the entry count, into their legal ranges
    always_comb begin
        cfg_block = i_cfg_data;
        if (cfg_block < BLOCK_MIN) begin
            cfg_block = BLOCK_MIN;
        end else if (cfg_block > BLOCK_MAX) begin
            cfg_block = BLOCK_MAX;
        end
        cfg_maxu = i_cfg_data[MAXU_W-1:0];
        if (cfg_maxu < MAXU_MIN) begin
            cfg_maxu = MAXU_MIN;
        end else if (32'(cfg_maxu) > 32'(MAX_ENTRIES)) begin
            cfg_maxu = MAXU_W'(MAX_ENTRIES);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block    <= BLOCK_RESET;
            r_max_used <= MAXU_RESET;
        end else if (cfg_xfer) begin
            unique case (i_cfg_addr)
                CFG_BLOCK_BYTES: r_block    <= cfg_block;
                CFG_MAX_ENTRIES: r_max_used <= cfg_maxu;
                default: ;
            endcase
        end
    end

    assign div_start = in_xfer && !in_bypass;

    lrbc_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (in_off),
        .i_divisor  (r_block),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    lrbc_tags #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_tags (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_start),
        .i_key_seg   (r_seg),
        .i_key_base  (r_key_base),
        .i_excl_en   (r_excl_en),
        .i_excl      (r_excl),
        .i_wr_en     (wr_en),
        .i_wr_tag    (r_miss),
        .i_wr_slot   (r_slot),
        .i_wr_data   (wr_data),
        .i_wr_tick   (r_stamp),
        .o_done      (scan_done),
        .o_flags     (scan_flags),
        .o_hit_slot  (hit_slot),
        .o_free_slot (free_slot),
        .o_vic_slot  (vic_slot),
        .o_valid_cnt (valid_cnt)
    );

    // Choose the entry and the fill size for this touch
    always_comb begin
        room = (32'(valid_cnt) < 32'(r_max_used));
        priority if (scan_flags.hit) begin
            pick_slot = hit_slot;
        end else if (room) begin
            pick_slot = free_slot;
        end else if (scan_flags.vic_found) begin
            pick_slot = vic_slot;
        end else if (r_excl_en && (r_excl == '0)) begin
            pick_slot = IW'(1);
        end else begin
            pick_slot = '0;
        end
        fill_raw = (r_key_base < r_seglen) ? (r_seglen - r_key_base) : '0;
        fill_cap = (fill_raw > ADDR_W'(r_block)) ? ADDR_W'(r_block) : fill_raw;
    end

    // Copy window and new totals for this touch
    always_comb begin
        avail      = (r_filled > BLK_W'(r_cstart)) ? (r_filled - BLK_W'(r_cstart)) : '0;
        copy_cnt   = (r_want < ADDR_W'(avail)) ? r_want : ADDR_W'(avail);
        bytes_next = r_bytes + CNT64_W'(r_fill);
        fetch_next = r_fetch + CNT64_W'(r_miss);
        touch_last = !r_straddle || r_second;
        wr_en      = (r_state == S_COPY);
        wr_data.seg    = r_seg;
        wr_data.base   = r_key_base;
        wr_data.filled = r_fill[BLK_W-1:0];
        out_free   = !r_out_valid || i_m_tready;
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = in_bypass ? S_EMIT : S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_PREP;
                end
            end
            S_PREP:   n_state = S_SCAN;
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: n_state = S_COPY;
            S_COPY:   n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = r_res.last ? S_IDLE : S_SCAN;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Control state: sequencer, scan start, counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_tick      <= '0;
            r_bytes     <= '0;
            r_fetch     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= ((r_state == S_PREP) ||
                        ((r_state == S_EMIT) && out_free && !r_res.last));
            // count the bypass fetch
            if (in_xfer && in_bypass) begin
                r_bytes <= r_bytes + CNT64_W'(in_len);
                r_fetch <= r_fetch + 1'b1;
            end
            // count a cached fetch and advance the tick after the last touch
            if (r_state == S_COPY) begin
                r_bytes <= bytes_next;
                r_fetch <= fetch_next;
                if (touch_last) begin
                    r_tick <= r_tick + (r_straddle ? CNT64_W'(4) : CNT64_W'(2));
                end
            end
            // output register: take a new result, drop one that transfers
            if ((r_state == S_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request datapath
    always_ff @(posedge i_clk) begin
        // capture the request
        if (in_xfer) begin
            r_seg    <= in_seg;
            r_off    <= in_off;
            r_len    <= in_len;
            r_seglen <= in_seglen;
        end
        // first touch setup from the remainder
        if (r_state == S_PREP) begin
            r_base0    <= r_off - ADDR_W'(div_rem);
            r_key_base <= r_off - ADDR_W'(div_rem);
            r_straddle <= ((ADDR_W+1)'(div_rem) + (ADDR_W+1)'(r_len)) >
                          (ADDR_W+1)'(r_block);
            r_cstart   <= div_rem;
            r_want     <= r_len;
            r_dest     <= '0;
            r_excl_en  <= 1'b0;
            r_excl     <= '0;
            r_second   <= 1'b0;
        end
        // stamp of the first touch depends on the straddle found above
        if (r_start && !r_second) begin
            r_stamp <= r_tick + (r_straddle ? CNT64_W'(2) : CNT64_W'(1));
        end
        // resolve the entry for this touch
        if (r_state == S_DECIDE) begin
            r_slot   <= pick_slot;
            r_miss   <= !scan_flags.hit;
            r_ev     <= !scan_flags.hit && !room && scan_flags.vic_found;
            r_fill   <= scan_flags.hit ? '0 : fill_cap;
            r_filled <= scan_flags.hit ? scan_flags.hit_filled : fill_cap[BLK_W-1:0];
        end
        // build the result and set up the second touch
        if (r_state == S_COPY) begin
            r_res.action              <= r_miss ? ACT_MISS : ACT_HIT;
            r_res.slot                <= SLOT_OUT_W'(r_slot);
            r_res.block_base          <= r_key_base;
            r_res.fill_length         <= r_fill;
            r_res.copy_start          <= r_cstart;
            r_res.copy_count          <= copy_cnt;
            r_res.dest_offset         <= r_dest;
            r_res.evicted             <= r_ev;
            r_res.total_bytes_read    <= bytes_next;
            r_res.total_disk_accesses <= fetch_next;
            r_res.last                <= touch_last;
            if (!touch_last) begin
                r_second   <= 1'b1;
                r_key_base <= r_base0 + ADDR_W'(r_block);
                r_cstart   <= '0;
                r_want     <= r_want - copy_cnt;
                r_dest     <= copy_cnt[BLK_W-1:0];
                r_excl_en  <= 1'b1;
                r_excl     <= r_slot;
                r_stamp    <= r_stamp + 1'b1;
            end
        end
        // bypass result straight from the request
        if (in_xfer && in_bypass) begin
            r_res.action              <= ACT_BYPASS;
            r_res.slot                <= '0;
            r_res.block_base          <= in_off;
            r_res.fill_length         <= in_len;
            r_res.copy_start          <= '0;
            r_res.copy_count          <= in_len;
            r_res.dest_offset         <= '0;
            r_res.evicted             <= 1'b0;
            r_res.total_bytes_read    <= r_bytes + CNT64_W'(in_len);
            r_res.total_disk_accesses <= r_fetch + 1'b1;
            r_res.last                <= 1'b1;
        end
        // output payload
        if ((r_state == S_EMIT) && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.action;
    assign o_m_tlast  = r_out.last;
    assign o_m_tdata  = {2'b00,
                         r_out.total_disk_accesses,
                         r_out.total_bytes_read,
                         r_out.evicted,
                         r_out.dest_offset,
                         r_out.copy_count,
                         r_out.copy_start,
                         r_out.fill_length,
                         r_out.block_base,
                         r_out.slot};

    // A bypass result always ends its request
    a_bypass_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == ACT_BYPASS)) |-> o_m_tlast)
        else $error("bypass result without tlast");

    // Only a miss can replace an entry
    a_evict_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[141]) |-> (o_m_tuser == ACT_MISS))
        else $error("eviction reported without a miss");

    // Each cached miss counts exactly one fetch
    a_fetch_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_COPY) && r_miss) |=> (r_fetch == $past(r_fetch) + 1'b1))
        else $error("fetch count did not advance by one on a miss");

endmodule
